/* design/chunked_frame_reassembler_unit_assert.svh */
// assertion macros shared by the reassembler rtl
`ifndef CHUNKED_FRAME_REASSEMBLER_UNIT_ASSERT_SVH
`define CHUNKED_FRAME_REASSEMBLER_UNIT_ASSERT_SVH

// checked at every rising clock edge, switched off while reset is high
`define CFR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every rising clock edge, reset included
`define CFR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* design/cfr_pkg.sv */
// shared types and constants of the chunked frame reassembler
package cfr_pkg;

   localparam int CHUNK_BYTES_DEF = 128;
   localparam int FRAME_BYTES_DEF = 32768;
   localparam int HEADER_BYTES    = 6;

   localparam int ACTION_W  = 2;
   localparam int FRAME_ID_W = 16;
   localparam int COUNT_W   = 8;
   localparam int PKT_LEN_W = 16;
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 15;
   localparam int STATUS_W  = 3;
   localparam int LENGTH_W  = 16;
   // index * chunk size + payload length, and the frame size itself
   localparam int END_W     = 17;

   localparam logic [FRAME_ID_W-1:0] NO_FRAME = 16'hFFFF;

   typedef enum logic [ACTION_W-1:0] {
      ACT_HEADER = 2'd0,
      ACT_BYTE   = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_MALFORMED = 3'd1,
      ST_MISMATCH  = 3'd2,
      ST_OVERFLOW  = 3'd3,
      ST_IGNORED   = 3'd4
   } status_type;

endpackage

/* design/cfr_req_if.sv */
// request channel: chunk headers, payload bytes and frame reads
interface cfr_req_if import cfr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [FRAME_ID_W-1:0] frame_id;
   logic [COUNT_W-1:0]    chunk_index;
   logic [COUNT_W-1:0]    chunk_total;
   logic [COUNT_W-1:0]    payload_len;
   logic [PKT_LEN_W-1:0]  packet_len;
   logic [BYTE_W-1:0]     data_byte;
   logic [ADDR_W-1:0]     read_addr;

   modport source (
      output valid, action, frame_id, chunk_index, chunk_total, payload_len,
             packet_len, data_byte, read_addr,
      input  ready
   );
   modport sink (
      input  valid, action, frame_id, chunk_index, chunk_total, payload_len,
             packet_len, data_byte, read_addr,
      output ready
   );
endinterface

/* design/cfr_rsp_if.sv */
// response channel: one result per request transfer
interface cfr_rsp_if import cfr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                frame_done;
   logic [LENGTH_W-1:0] frame_length;
   logic [BYTE_W-1:0]   read_data;

   modport source (
      output valid, status, frame_done, frame_length, read_data,
      input  ready
   );
   modport sink (
      input  valid, status, frame_done, frame_length, read_data,
      output ready
   );
endinterface

/* design/chunked_frame_reassembler_unit.sv */
// Chunked frame reassembler. Every request transfer (chunk header, payload
// byte or frame read) is handled in its transfer cycle, so a transfer can be
// taken on every clock while the request side is not stalled. Its result
// passes the pipe stage and then the output register, which offers it on the
// response channel. The frame buffer is a synchronous RAM of
// FRAME_BYTES bytes with one write and one read port. A payload byte writes it
// in its transfer cycle. A read request gets its byte while it sits in the pipe
// stage, and the output register then holds that byte. With a pipe stage and an
// output register between the channels, one more transfer is still taken while
// a finished result waits; after that the request side stalls until the
// response is taken.
// The buffer has no clearing pass: bytes never written read back undefined.
module chunked_frame_reassembler_unit
   import cfr_pkg::*;
#(
   parameter int CHUNK_BYTES = CHUNK_BYTES_DEF,
   parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   cfr_req_if.sink   req_chan,
   cfr_rsp_if.source rsp_chan
);

   `include "chunked_frame_reassembler_unit_assert.svh"

   localparam int MEM_AW = $clog2(FRAME_BYTES);
   localparam logic [END_W-1:0] FRAME_END = END_W'(FRAME_BYTES);
   localparam logic [END_W-1:0] CHUNK_SIZE = END_W'(CHUNK_BYTES);
   localparam logic [END_W-1:0] HDR_SIZE = END_W'(HEADER_BYTES);

   // frame buffer
   logic [BYTE_W-1:0] frame_mem [FRAME_BYTES];
   logic [BYTE_W-1:0] mem_rd_ff;
   logic              mem_we;
   logic              mem_re;
   logic [MEM_AW-1:0] mem_raddr;

   // assembly and pending-chunk state
   logic [FRAME_ID_W-1:0] cur_frame_ff, cur_frame_in;
   logic [COUNT_W-1:0]    needed_ff, needed_in;
   logic [COUNT_W-1:0]    got_ff, got_in;
   logic [END_W-1:0]      high_water_ff, high_water_in;
   logic [MEM_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [COUNT_W-1:0]    bytes_left_ff, bytes_left_in;
   logic                  done_on_last_ff, done_on_last_in;
   logic [LENGTH_W-1:0]   done_len_ff, done_len_in;

   // pipe stage and output register
   logic                p1_valid_ff;
   status_type          p1_status_ff, p1_status_in;
   logic                p1_done_ff, p1_done_in;
   logic [LENGTH_W-1:0] p1_length_ff, p1_length_in;
   logic                p1_rd_ff, p1_rd_in;
   logic                out_valid_ff;
   status_type          out_status_ff;
   logic                out_done_ff;
   logic [LENGTH_W-1:0] out_length_ff;
   logic [BYTE_W-1:0]   out_data_ff;

   logic req_accept;
   logic p1_adv;

   // header arithmetic
   logic [END_W-1:0]  hdr_need;
   logic [END_W-1:0]  chunk_offset;
   logic [END_W-1:0]  chunk_end;
   logic              hdr_malformed;
   logic [COUNT_W-1:0] got_step;

   assign p1_adv       = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !p1_valid_ff || p1_adv;
   assign req_accept   = req_chan.valid && req_chan.ready;

   assign hdr_need      = HDR_SIZE + END_W'(req_chan.payload_len);
   assign hdr_malformed = hdr_need > END_W'(req_chan.packet_len);
   assign chunk_offset  = END_W'(req_chan.chunk_index) * CHUNK_SIZE;
   assign chunk_end     = chunk_offset + END_W'(req_chan.payload_len);

   assign mem_raddr = MEM_AW'(req_chan.read_addr);

   always_comb begin
      cur_frame_in    = cur_frame_ff;
      needed_in       = needed_ff;
      got_in          = got_ff;
      high_water_in   = high_water_ff;
      wr_ptr_in       = wr_ptr_ff;
      bytes_left_in   = bytes_left_ff;
      done_on_last_in = done_on_last_ff;
      done_len_in     = done_len_ff;
      p1_status_in    = ST_OK;
      p1_done_in      = 1'b0;
      p1_length_in    = '0;
      p1_rd_in        = 1'b0;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      got_step        = '0;

      if (req_accept) begin
         case (req_chan.action)
            ACT_HEADER: begin
               if (hdr_malformed) begin
                  p1_status_in = ST_MALFORMED;
               end else begin
                  // a new frame id restarts assembly with its own total
                  if (req_chan.frame_id != cur_frame_ff) begin
                     cur_frame_in  = req_chan.frame_id;
                     needed_in     = req_chan.chunk_total;
                     got_in        = '0;
                     high_water_in = '0;
                  end
                  if (req_chan.chunk_total != needed_in || chunk_end > FRAME_END) begin
                     p1_status_in    = (req_chan.chunk_total != needed_in) ?
                                       ST_MISMATCH : ST_OVERFLOW;
                     cur_frame_in    = NO_FRAME;
                     needed_in       = '0;
                     got_in          = '0;
                     high_water_in   = '0;
                     bytes_left_in   = '0;
                     done_on_last_in = 1'b0;
                     done_len_in     = '0;
                  end else begin
                     wr_ptr_in       = chunk_offset[MEM_AW-1:0];
                     bytes_left_in   = req_chan.payload_len;
                     done_on_last_in = 1'b0;
                     done_len_in     = '0;
                     if (chunk_end > high_water_in) begin
                        high_water_in = chunk_end;
                     end
                     got_step = got_in + 1'b1;
                     got_in   = got_step;
                     if (got_step == needed_in) begin
                        // completion: state resets now, signalled on the last byte, or at once for an empty chunk
                        if (req_chan.payload_len == '0) begin
                           p1_done_in   = 1'b1;
                           p1_length_in = high_water_in[LENGTH_W-1:0];
                        end else begin
                           done_on_last_in = 1'b1;
                           done_len_in     = high_water_in[LENGTH_W-1:0];
                        end
                        cur_frame_in  = NO_FRAME;
                        needed_in     = '0;
                        got_in        = '0;
                        high_water_in = '0;
                     end
                  end
               end
            end
            ACT_BYTE: begin
               if (bytes_left_ff == '0) begin
                  p1_status_in = ST_IGNORED;
               end else begin
                  mem_we        = 1'b1;
                  wr_ptr_in     = wr_ptr_ff + 1'b1;
                  bytes_left_in = bytes_left_ff - 1'b1;
                  if (bytes_left_ff == COUNT_W'(1) && done_on_last_ff) begin
                     p1_done_in      = 1'b1;
                     p1_length_in    = done_len_ff;
                     done_on_last_in = 1'b0;
                     done_len_in     = '0;
                  end
               end
            end
            ACT_READ: begin
               mem_re   = 1'b1;
               p1_rd_in = END_W'(req_chan.read_addr) < FRAME_END;
            end
            default: begin
               p1_status_in = ST_IGNORED;
            end
         endcase
      end
   end

   // frame buffer ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_ptr_ff] <= req_chan.data_byte;
      end
      if (mem_re) begin
         mem_rd_ff <= frame_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_frame_ff    <= NO_FRAME;
         needed_ff       <= '0;
         got_ff          <= '0;
         high_water_ff   <= '0;
         wr_ptr_ff       <= '0;
         bytes_left_ff   <= '0;
         done_on_last_ff <= 1'b0;
         done_len_ff     <= '0;
         p1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         cur_frame_ff    <= cur_frame_in;
         needed_ff       <= needed_in;
         got_ff          <= got_in;
         high_water_ff   <= high_water_in;
         wr_ptr_ff       <= wr_ptr_in;
         bytes_left_ff   <= bytes_left_in;
         done_on_last_ff <= done_on_last_in;
         done_len_ff     <= done_len_in;
         if (req_accept) begin
            p1_valid_ff <= 1'b1;
         end else if (p1_adv) begin
            p1_valid_ff <= 1'b0;
         end
         if (p1_adv) begin
            out_valid_ff <= p1_valid_ff;
         end
      end
   end

   // payload of the pipe stage and output register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         p1_status_ff <= p1_status_in;
         p1_done_ff   <= p1_done_in;
         p1_length_ff <= p1_length_in;
         p1_rd_ff     <= p1_rd_in;
      end
      if (p1_adv) begin
         out_status_ff <= p1_status_ff;
         out_done_ff   <= p1_done_ff;
         out_length_ff <= p1_length_ff;
         out_data_ff   <= p1_rd_ff ? mem_rd_ff : '0;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.frame_done   = out_done_ff;
   assign rsp_chan.frame_length = out_length_ff;
   assign rsp_chan.read_data    = out_data_ff;

   // a pending completion always has bytes still to come
   `CFR_ASSERT(a_done_has_bytes, done_on_last_ff |-> bytes_left_ff != '0, "done, no bytes")
   // a transfer always lands in the pipe stage
   `CFR_ASSERT(a_accept_fills_pipe, req_accept |=> p1_valid_ff, "accepted transfer lost")
   // a completed frame is only reported with ok status
   `CFR_ASSERT(a_done_ok, out_valid_ff && out_done_ff |-> out_status_ff == ST_OK, "done, bad status")
   // length is zero unless a frame completed
   `CFR_ASSERT(a_len_only_done, out_valid_ff && !out_done_ff |-> out_length_ff == '0, "stray length")
   // an empty pipe stage never stalls the request side
   `CFR_ASSERT_ALWAYS(a_ready_when_empty, !p1_valid_ff |-> req_chan.ready, "empty pipe stalls")

endmodule
